/* rtl/core/fa2_pkg.sv */
// Shared types and constants for the fixed-point atan2 pipeline.
`timescale 1ns / 1ps

package fa2_pkg;

  // Region codes: which approximation an item uses.
  localparam logic [1:0] REG_LOW  = 2'd0;  // |y| small against |x|: Pade of y/x
  localparam logic [1:0] REG_HIGH = 2'd1;  // |x| small against |y|: pi/2 minus Pade of x/y
  localparam logic [1:0] REG_MID  = 2'd2;  // near the diagonal: Pade about one

  // pi with 62 fraction bits, rounded up; scaled copies are rounded at elaboration.
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  // Flags that travel beside the data through every stage.
  typedef struct packed {
    logic [1:0] region;
    logic       xneg;     // abscissa is negative
    logic       yneg;     // ordinate is negative
    logic       dneg;     // operands of the ratio differ in sign
    logic       rneg;     // signed ratio is below zero
    logic       pneg;     // Pade numerator is below zero
    logic       zero;     // both inputs are zero
    logic       negaxis;  // x is zero and y is negative
  } side_t;

endpackage

/* rtl/core/fa2_div.sv */
// Pipelined restoring divider that retires one quotient bit per stage.
`timescale 1ns / 1ps

module fa2_div #(
  parameter int QW = 17,
  parameter int DW = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [DW-1:0]        in_rem,
  input  logic [QW-1:0]        in_bits,
  input  logic [DW-1:0]        in_den,
  input  fa2_pkg::side_t       in_side,
  output logic                 out_valid,
  output logic [QW-1:0]        out_quo,
  output fa2_pkg::side_t       out_side
);

  logic [QW-1:0]  vld;
  logic [DW-1:0]  rem  [QW];
  logic [QW-1:0]  quo  [QW];
  logic [QW-1:0]  bits [QW];
  logic [DW-1:0]  den  [QW];
  fa2_pkg::side_t side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic           prev_vld;
    logic [DW-1:0]  prev_rem;
    logic [QW-1:0]  prev_quo;
    logic [QW-1:0]  prev_bits;
    logic [DW-1:0]  prev_den;
    fa2_pkg::side_t prev_side;
    logic [DW:0]    trial;
    logic           fits;
    logic [DW-1:0]  rem_next;

    // Select the previous stage, or the inputs for the first one.
    if (k == 0) begin : g_first
      assign prev_vld  = in_valid;
      assign prev_rem  = in_rem;
      assign prev_quo  = '0;
      assign prev_bits = in_bits;
      assign prev_den  = in_den;
      assign prev_side = in_side;
    end else begin : g_next
      assign prev_vld  = vld[k-1];
      assign prev_rem  = rem[k-1];
      assign prev_quo  = quo[k-1];
      assign prev_bits = bits[k-1];
      assign prev_den  = den[k-1];
      assign prev_side = side[k-1];
    end

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
      trial    = {prev_rem, prev_bits[QW-1]};
      fits     = trial >= {1'b0, prev_den};
      rem_next = fits ? DW'(trial - {1'b0, prev_den}) : DW'(trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= prev_vld;
      end
      rem[k]  <= rem_next;
      quo[k]  <= {prev_quo[QW-2:0], fits};
      bits[k] <= {prev_bits[QW-2:0], 1'b0};
      den[k]  <= prev_den;
      side[k] <= prev_side;
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_side  = side[QW-1];

endmodule

/* rtl/core/fixed_atan2_pade.sv */
// Top level of the fully pipelined fixed-point atan2 unit.
`timescale 1ns / 1ps

// Four-quadrant arctangent of a signed fixed-point pair (y_value, x_value).
// Input channel: a transfer happens at each rising edge with start high and
// busy low. busy is always low, so one item may enter in every cycle.
// Output channel: done is high for exactly one cycle with angle valid; the
// transfer completes at the edge that ends that cycle. The receiver cannot
// hold results off, and none is needed since the pipeline never waits.
// Pipeline: two bit-per-stage dividers (FRAC_BITS + 2 stages for the ratio,
// FRAC_BITS stages for the Pade quotient) plus one classify stage, one
// argument stage, three multiply stages, one select stage and one output
// stage. Throughput: one item per cycle.
// Reset clears every valid bit; items in flight are dropped and done stays
// low until new items come through. Angles are clamped to [-pi, pi] and to
// the signed 18-bit output range.
module fixed_atan2_pade #(
  parameter int FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] y_value,
  input  logic signed [31:0] x_value,
  output logic               done,
  output logic signed [17:0] angle
);

  localparam int F    = FRAC_BITS;
  localparam int QRW  = F + 2;            // ratio quotient bits
  localparam int TW   = F + 3;            // Pade argument width
  localparam int PW   = F + 13;           // polynomial term width
  localparam int MW   = TW + PW;          // product width
  localparam int RESW = (F + 5 > 19) ? F + 5 : 19;
  localparam int LAT  = 2 * F + 9;

  localparam logic [63:0] PI_U = (fa2_pkg::PI_Q62 + (64'd1 << (61 - F))) >> (62 - F);
  localparam logic [63:0] HP_U = (fa2_pkg::PI_Q62 + (64'd1 << (62 - F))) >> (63 - F);
  localparam logic [63:0] P4_U = (fa2_pkg::PI_Q62 + (64'd1 << (63 - F))) >> (64 - F);
  localparam logic signed [RESW-1:0] PI_R = RESW'(PI_U);
  localparam logic signed [RESW-1:0] HP_R = RESW'(HP_U);
  localparam logic signed [RESW-1:0] P4_R = RESW'(P4_U);
  localparam logic signed [RESW-1:0] A_MAX = RESW'(131071);
  localparam logic signed [RESW-1:0] A_MIN = -RESW'(131072);

  localparam logic signed [TW-1:0] ONE_T = TW'(1) << F;
  localparam logic signed [PW-1:0] C60  = PW'(60) << F;
  localparam logic signed [PW-1:0] C90  = PW'(90) << F;
  localparam logic signed [PW-1:0] C105 = PW'(105) << F;
  localparam logic signed [PW-1:0] C108 = PW'(108) << F;
  localparam logic signed [PW-1:0] C120 = PW'(120) << F;
  localparam logic signed [PW-1:0] C180 = PW'(180) << F;
  localparam logic signed [PW-1:0] K9  = PW'(9);
  localparam logic signed [PW-1:0] K19 = PW'(19);
  localparam logic signed [PW-1:0] K24 = PW'(24);
  localparam logic signed [PW-1:0] K55 = PW'(55);

  // Fixed product, floor(a*b / 2^F), exact.
  function automatic logic signed [PW-1:0] fmul(input logic signed [TW-1:0] a,
                                                 input logic signed [PW-1:0] b);
    logic signed [MW-1:0] m;
    m = MW'(a) * MW'(b);
    return PW'(m >>> F);
  endfunction

  assign busy = 1'b0;

  // Classify: magnitudes, region tests and ratio operands.
  logic        [32:0] ay, ax;
  logic        [31:0] ayh, axh;
  logic signed [31:0] yh, xh;
  logic               in_low, in_high;
  fa2_pkg::side_t     side_in;

  always_comb begin
    ay  = y_value[31] ? 33'd0 - {1'b1, y_value} : {1'b0, y_value};
    ax  = x_value[31] ? 33'd0 - {1'b1, x_value} : {1'b0, x_value};
    yh  = y_value >>> 1;
    xh  = x_value >>> 1;
    ayh = yh[31] ? 32'd0 - yh : yh;
    axh = xh[31] ? 32'd0 - xh : xh;
    in_low  = ay <= {1'b0, axh};
    in_high = ax <= {1'b0, ayh};
    side_in         = '0;
    side_in.region  = in_low ? fa2_pkg::REG_LOW :
                      (in_high ? fa2_pkg::REG_HIGH : fa2_pkg::REG_MID);
    side_in.xneg    = x_value[31];
    side_in.yneg    = y_value[31];
    side_in.dneg    = x_value[31] ^ y_value[31];
    side_in.zero    = (x_value == 32'sd0) && (y_value == 32'sd0);
    side_in.negaxis = (x_value == 32'sd0) && y_value[31];
  end

  logic           s0_valid;
  logic [32:0]    s0_num, s0_den;
  fa2_pkg::side_t s0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start;
    end
    s0_num  <= (!in_low && in_high) ? ax : ay;
    s0_den  <= (!in_low && in_high) ? ay : ax;
    s0_side <= side_in;
  end

  // Ratio divider: (num * 2^F) / den, the quotient stays below four.
  logic           rd_valid;
  logic [QRW-1:0] rd_quo;
  fa2_pkg::side_t rd_side;

  fa2_div #(.QW(QRW), .DW(33)) u_ratio_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s0_valid),
    .in_rem   (s0_num >> 2),
    .in_bits  ({s0_num[1:0], F'(0)}),
    .in_den   (s0_den),
    .in_side  (s0_side),
    .out_valid(rd_valid),
    .out_quo  (rd_quo),
    .out_side (rd_side)
  );

  // Pade arguments: signed ratio for the outer regions, |ratio| - 1 for the middle.
  logic                 t_valid;
  fa2_pkg::side_t       t_side;
  fa2_pkg::side_t       rd_side_next;
  logic signed [TW-1:0] t_t34, t_t33, qs;

  assign qs = TW'(rd_quo);

  // The ratio is negative only when the operands differ in sign and it is nonzero.
  always_comb begin
    rd_side_next      = rd_side;
    rd_side_next.rneg = rd_side.dneg && (rd_quo != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else begin
      t_valid <= rd_valid;
    end
    t_side <= rd_side_next;
    t_t34  <= rd_side.dneg ? -qs : qs;
    t_t33  <= qs - ONE_T;
  end

  // First multiply stage: t squared and the linear terms of the middle Pade.
  logic                 m1_valid;
  fa2_pkg::side_t       m1_side;
  logic signed [TW-1:0] m1_t34, m1_t33, m1_t2;
  logic signed [PW-1:0] m1_a, m1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= t_valid;
    end
    m1_side <= t_side;
    m1_t34  <= t_t34;
    m1_t33  <= t_t33;
    m1_t2   <= TW'(fmul(t_t34, PW'(t_t34)));
    m1_a    <= C60 + K19 * PW'(t_t33);
    m1_d    <= C108 + K24 * PW'(t_t33);
  end

  // Second multiply stage.
  logic                 m2_valid;
  fa2_pkg::side_t       m2_side;
  logic signed [TW-1:0] m2_t33;
  logic signed [PW-1:0] m2_n34, m2_w34, m2_b, m2_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
    m2_side <= m1_side;
    m2_t33  <= m1_t33;
    m2_n34  <= fmul(m1_t34, C105 + K55 * PW'(m1_t2));
    m2_w34  <= fmul(m1_t2, C90 + K9 * PW'(m1_t2));
    m2_b    <= fmul(m1_t33, m1_a);
    m2_e    <= fmul(m1_t33, m1_d);
  end

  // Third multiply stage.
  logic                 m3_valid;
  fa2_pkg::side_t       m3_side;
  logic signed [PW-1:0] m3_n34, m3_den34, m3_n33, m3_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else begin
      m3_valid <= m2_valid;
    end
    m3_side  <= m2_side;
    m3_n34   <= m2_n34;
    m3_den34 <= C105 + m2_w34;
    m3_n33   <= fmul(m2_t33, C60 + m2_b);
    m3_g     <= fmul(m2_t33, C180 + m2_e);
  end

  // Select numerator and denominator of the Pade quotient and take magnitudes.
  logic                 m4_valid;
  fa2_pkg::side_t       m4_side;
  fa2_pkg::side_t       m3_side_next;
  logic [PW-1:0]        m4_num, m4_den;
  logic signed [PW-1:0] sel_num;
  logic                 sel_mid;

  assign sel_mid = m3_side.region == fa2_pkg::REG_MID;
  assign sel_num = sel_mid ? m3_n33 : m3_n34;

  // Remember the numerator sign so the quotient can be negated afterwards.
  always_comb begin
    m3_side_next      = m3_side;
    m3_side_next.pneg = sel_num[PW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_valid <= 1'b0;
    end else begin
      m4_valid <= m3_valid;
    end
    m4_side <= m3_side_next;
    m4_num  <= sel_num[PW-1] ? PW'(-sel_num) : PW'(sel_num);
    m4_den  <= sel_mid ? PW'(C120 + m3_g) : PW'(m3_den34);
  end

  // Pade divider: the quotient magnitude stays below one.
  logic           pd_valid;
  logic [F-1:0]   pd_quo;
  fa2_pkg::side_t pd_side;

  fa2_div #(.QW(F), .DW(PW)) u_pade_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m4_valid),
    .in_rem   (m4_num),
    .in_bits  ('0),
    .in_den   (m4_den),
    .in_side  (m4_side),
    .out_valid(pd_valid),
    .out_quo  (pd_quo),
    .out_side (pd_side)
  );

  // Fold in the region, the quadrant and the boundary cases, then clamp.
  logic signed [RESW-1:0] pmag, pval, base, quad, clip;

  always_comb begin
    pmag = RESW'(pd_quo);
    pval = pd_side.pneg ? -pmag : pmag;
    case (pd_side.region)
      fa2_pkg::REG_LOW:  base = pval;
      fa2_pkg::REG_HIGH: base = (pd_side.rneg ? -HP_R : HP_R) - pval;
      fa2_pkg::REG_MID:  base = pd_side.rneg ? -(P4_R + pval) : P4_R + pval;
      default:           base = '0;
    endcase
    quad = base;
    if (pd_side.xneg) begin
      quad = pd_side.yneg ? base - PI_R : base + PI_R;
    end
    if (pd_side.zero) begin
      quad = '0;
    end else if (pd_side.negaxis) begin
      quad = -HP_R;
    end
    clip = quad;
    if (clip > PI_R) begin
      clip = PI_R;
    end
    if (clip < -PI_R) begin
      clip = -PI_R;
    end
    if (clip > A_MAX) begin
      clip = A_MAX;
    end
    if (clip < A_MIN) begin
      clip = A_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pd_valid;
    end
    angle <= 18'(clip);
  end

`ifndef SYNTHESIS
  // Every accepted item comes out with done high once it has passed the whole pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted item did not complete on time");

  // A result is never announced without a matching accepted item.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(start && !busy, LAT))
    else $error("result without a matching input");

  // The origin maps to zero through the whole pipeline.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (x_value == 32'sd0) && (y_value == 32'sd0))
      |-> ##LAT (done && (angle == 18'sd0)))
    else $error("atan2 of the origin is not zero");

  // Results stay within minus pi to pi.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (($signed(angle) <= PI_R) && ($signed(angle) >= -PI_R)))
    else $error("angle outside minus pi to pi");
`endif

endmodule

/* tb/fixed_atan2_pade_checker.sv */
// Checker for the atan2 unit: predicts each angle and compares it on the done strobe.
`timescale 1ns / 1ps

module fixed_atan2_pade_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] y_value,
  input  logic signed [31:0] x_value,
  input  logic               done,
  input  logic signed [17:0] angle,
  output int                 fail_count,
  output int                 pending,
  output int                 item_count,
  output int                 angle_count
);

  localparam int      FB      = 15;
  localparam longint  ONE     = longint'(1) << FB;
  localparam longint  OUT_MAX = 131071;
  localparam longint  OUT_MIN = -131072;

  logic signed [17:0] angle_queue[$];

  // pi scaled by 2^-extra, rounded to nearest at FB fraction bits.
  function automatic longint pi_frac(int extra);
    logic [63:0] rounded;
    int          sh;
    sh      = 62 + extra - FB;
    rounded = (fa2_pkg::PI_Q62 + (64'd1 << (sh - 1))) >> sh;
    return longint'(rounded);
  endfunction

  // Fixed product, floored.
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  // Fixed quotient, truncated toward zero; zero divisor answers zero.
  function automatic longint fx_div(longint a, longint b);
    if (b == 0) begin
      return 0;
    end
    return (a <<< FB) / b;
  endfunction

  function automatic longint atan_pade34(longint t);
    longint t2;
    longint num;
    longint den;
    t2  = fx_mul(t, t);
    num = fx_mul(t, 105 * ONE + t2 * 55);
    den = 105 * ONE + fx_mul(t2, 90 * ONE + t2 * 9);
    return fx_div(num, den);
  endfunction

  function automatic longint atan_pade33(longint t);
    longint num;
    longint den;
    num = fx_mul(t, 60 * ONE + fx_mul(t, 60 * ONE + t * 19));
    den = 120 * ONE + fx_mul(t, 180 * ONE + fx_mul(t, 108 * ONE + t * 24));
    return pi_frac(2) + fx_div(num, den);
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Expected angle for one ordinate/abscissa pair.
  function automatic logic signed [17:0] atan2_expected(longint y, longint x);
    longint pi_v;
    longint half_pi;
    longint res;
    longint r;
    pi_v    = pi_frac(0);
    half_pi = pi_frac(1);
    if (x == 0 && y == 0) begin
      res = 0;
    end else if (x == 0 && y < 0) begin
      res = -half_pi;
    end else begin
      if (abs_l(y) <= abs_l(x >>> 1)) begin
        res = atan_pade34(fx_div(y, x));
      end else if (abs_l(x) <= abs_l(y >>> 1)) begin
        r   = fx_div(x, y);
        res = ((r >= 0) ? half_pi : -half_pi) - atan_pade34(r);
      end else begin
        r = fx_div(y, x);
        if (r >= 0) begin
          res = atan_pade33(r - ONE);
        end else begin
          res = -atan_pade33(-r - ONE);
        end
      end
      // Quadrant correction for a negative abscissa.
      if (x < 0) begin
        res = (y < 0) ? res - pi_v : res + pi_v;
      end
    end
    if (res > pi_v) res = pi_v;
    if (res < -pi_v) res = -pi_v;
    if (res > OUT_MAX) res = OUT_MAX;
    if (res < OUT_MIN) res = OUT_MIN;
    return res[17:0];
  endfunction

  assign pending = angle_queue.size();

  // Record accepted items and check each result against the oldest prediction.
  always @(posedge clk) begin
    logic signed [17:0] want;
    if (rst) begin
      fail_count  <= 0;
      item_count  <= 0;
      angle_count <= 0;
    end else begin
      if (start && !busy) begin
        angle_queue.push_back(atan2_expected(longint'(y_value), longint'(x_value)));
        item_count <= item_count + 1;
      end
      if (done) begin
        angle_count <= angle_count + 1;
        if (angle_queue.size() == 0) begin
          $error("angle: unexpected result %0d with nothing pending", angle);
          fail_count <= fail_count + 1;
        end else begin
          want = angle_queue.pop_front();
          if (angle !== want) begin
            $error("angle: expected %0d, actual %0d", want, angle);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/fixed_atan2_pade_test.sv */
// Top of the atan2 testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module fixed_atan2_pade_test;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [31:0] y_value;
  logic signed [31:0] x_value;
  logic               done;
  logic signed [17:0] angle;
  int                 fail_count;
  int                 pending;
  int                 item_count;
  int                 angle_count;

  fixed_atan2_pade i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .y_value(y_value), .x_value(x_value), .done(done), .angle(angle)
  );

  fixed_atan2_pade_checker i_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .y_value(y_value), .x_value(x_value), .done(done), .angle(angle),
    .fail_count(fail_count), .pending(pending),
    .item_count(item_count), .angle_count(angle_count)
  );

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety limit on the whole run.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // Random idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // One transfer, then an optional idle stretch.
  task automatic send_pair(logic signed [31:0] y, logic signed [31:0] x, int idle);
    start   <= 1'b1;
    y_value <= y;
    x_value <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Random pair shaped toward the region boundaries and small magnitudes.
  task automatic send_random(int idle);
    logic signed [31:0] y;
    logic signed [31:0] x;
    int                 mode;
    mode = $urandom_range(0, 5);
    y    = $urandom;
    x    = $urandom;
    case (mode)
      0: begin
      end
      1: begin
        y = $signed(y) >>> $urandom_range(0, 30);
        x = $signed(x) >>> $urandom_range(0, 30);
      end
      2: begin
        // Near a half-ratio boundary.
        x = $signed(x) >>> $urandom_range(1, 20);
        y = ($signed(x) >>> 1) + $signed($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) y = -y;
        if ($urandom_range(0, 1)) begin
          y = y ^ x;
          x = y ^ x;
          y = y ^ x;
        end
      end
      3: begin
        // Near the diagonal.
        x = $signed(x) >>> $urandom_range(1, 20);
        y = x + $signed($urandom_range(0, 8)) - 4;
        if ($urandom_range(0, 1)) y = -y;
      end
      4: begin
        // One axis zero or tiny.
        if ($urandom_range(0, 1)) x = $signed($urandom_range(0, 2)) - 1;
        else y = $signed($urandom_range(0, 2)) - 1;
      end
      default: begin
        y = $signed(y) >>> $urandom_range(10, 17);
        x = $signed(x) >>> $urandom_range(10, 17);
      end
    endcase
    send_pair(y, x, idle);
  endtask

  initial begin
    int k;
    rst     = 1'b1;
    start   = 1'b0;
    y_value = '0;
    x_value = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: zeros, axes, extremes, diagonals and region edges.
    send_pair(0, 0, 0);
    send_pair(-32768, 0, 0);
    send_pair(32768, 0, 0);
    send_pair(0, 32768, 1);
    send_pair(0, -32768, 0);
    send_pair(32'h7fffffff, 32'h7fffffff, 0);
    send_pair(32'h80000000, 32'h80000000, 2);
    send_pair(32'h80000000, 32'h7fffffff, 0);
    send_pair(32'h7fffffff, 32'h80000000, 0);
    send_pair(32'h80000000, 0, 0);
    send_pair(0, 32'h80000000, 0);
    send_pair(-1, -1, 0);
    send_pair(1, -1, 3);
    send_pair(16384, 32768, 0);
    send_pair(16385, 32768, 0);
    send_pair(32768, 16384, 0);
    send_pair(32768, 16385, 0);
    send_pair(-16384, -32768, 0);
    send_pair(-32768, -16385, 0);
    send_pair(-1, 32'h7fffffff, 0);
    send_pair(1, 32'h80000000, 0);
    send_pair(32'h7fffffff, -1, 0);
    send_pair(1, 0, 0);

    // Random part, with one full drain partway through.
    for (k = 0; k < 1600; k++) begin
      if (k == 800) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_random((k % 300 < 40) ? 0 : idle_len());
    end
    start <= 1'b0;

    // Drain the pipeline, then allow some settling time.
    k = 0;
    while (pending != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (50) @(posedge clk);

    $display("Run covered %0d transfers in and %0d angles out across all regions.",
             item_count, angle_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
